[hw/rtl/weighted_pattern_matcher_defines.svh]
// Assertion macros for the weighted pattern matcher checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WEIGHTED_PATTERN_MATCHER_DEFINES_SVH
`define WEIGHTED_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weighted_pattern_matcher check failed");

// Next-cycle implication, disabled in reset.
`define WPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weighted_pattern_matcher check failed");

`endif

[hw/rtl/wpm_pkg.sv]
// Shared types and constants for the weighted pattern matcher.
// No dependencies; imported by the top level, both checkers and the testbench.
`default_nettype none

package wpm_pkg;

	localparam int unsigned FUNC_W = 2;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TEXT        = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_LETTER = 2'd2;

	localparam int unsigned CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_PATTERN_LENGTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_ALPHABET_SIZE   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MIN_PROBABILITY = 2'd2;

	localparam int unsigned Q_W   = 17;
	localparam int unsigned POS_W = 6;
	localparam int unsigned LET_W = 4;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned IDX_W = 32;
	localparam int unsigned PL_W  = 7;
	localparam int unsigned AS_W  = 5;

	localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_AW    = 3;

	typedef logic [Q_W-1:0] prob_t;

endpackage

`default_nettype wire

[hw/rtl/weighted_pattern_matcher.sv]
// Weighted pattern matcher top level: weight banks, window product cells, result queue.
// Depends on wpm_pkg.
`default_nettype none

// Streams text bytes through MAX_PATTERN window cells, with one multiply per byte in
// every cell but cell 0, and reports the start index of each window whose Q1.16
// product reaches min_probability. One item (load or text byte) is accepted every
// cycle while in_ready is high. An accepted text beat passes these steps in order:
// input register, alphabet compare, weight bank read (one bank of MAX_ALPHABET
// entries per pattern position, registered read), cell multiply, threshold compare
// into an 8-entry result queue. in_ready drops only while queued plus in-flight
// items reach the queue depth, so the input keeps flowing while a result waits.
// Configuration writes take effect on the next cycle.
module weighted_pattern_matcher #(
	parameter int unsigned MAX_PATTERN  = 64,
	parameter int unsigned MAX_ALPHABET = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [wpm_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [wpm_pkg::Q_W-1:0]      cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [wpm_pkg::FUNC_W-1:0]   func,
	input  wire logic [wpm_pkg::POS_W-1:0]    pattern_pos,
	input  wire logic [wpm_pkg::LET_W-1:0]    letter_index,
	input  wire logic [wpm_pkg::Q_W-1:0]      weight,
	input  wire logic [wpm_pkg::SYM_W-1:0]    symbol,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [wpm_pkg::IDX_W-1:0]         match_start
);
	import wpm_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ALPHABET);
	localparam int unsigned PW = $clog2(MAX_PATTERN);
	localparam int unsigned MW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned CW = RES_AW + 1;

	logic [PL_W-1:0]  pattern_length_q;
	logic [AS_W-1:0]  alphabet_size_q;
	prob_t            min_probability_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q  <= PL_W'(1);
			alphabet_size_q   <= AS_W'(4);
			min_probability_q <= ONE_Q16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_LENGTH:  pattern_length_q  <= cfg_wdata[PL_W-1:0];
				CFG_ALPHABET_SIZE:   alphabet_size_q   <= cfg_wdata[AS_W-1:0];
				CFG_MIN_PROBABILITY: min_probability_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	logic              in_beat;
	logic              v_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [LET_W-1:0]  letter_s1;
	prob_t             weight_s1;
	logic [SYM_W-1:0]  symbol_s1;

	assign in_beat = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			func_s1   <= func;
			pos_s1    <= pattern_pos;
			letter_s1 <= letter_index;
			weight_s1 <= weight;
			symbol_s1 <= symbol;
		end
	end

	// alphabet store and lookup
	logic [SYM_W-1:0] alph_q [MAX_ALPHABET];
	logic             found_c;
	logic [AW-1:0]    code_c;
	logic             letter_ok;

	assign letter_ok = 32'(letter_s1) < MAX_ALPHABET;

	always_ff @(posedge clk) begin
		if (v_s1 && func_s1 == FUNC_LOAD_LETTER && letter_ok) begin
			alph_q[AW'(letter_s1)] <= symbol_s1;
		end
	end

	always_comb begin
		found_c = 1'b0;
		code_c  = '0;
		for (int j = 0; j < MAX_ALPHABET; j++) begin
			if (32'(alphabet_size_q) > j && alph_q[j] == symbol_s1) begin
				found_c = 1'b1;
				code_c  = AW'(j);
			end
		end
	end

	logic          text_s2;
	logic          found_s2;
	logic [AW-1:0] code_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_s2 <= 1'b0;
		end else begin
			text_s2 <= v_s1 && func_s1 == FUNC_TEXT;
		end
	end

	always_ff @(posedge clk) begin
		found_s2 <= found_c;
		code_s2  <= code_c;
	end

	// weight banks, one per pattern position
	prob_t wsat;
	logic  wload;
	prob_t w_s3 [MAX_PATTERN];

	assign wsat  = (weight_s1 > ONE_Q16) ? ONE_Q16 : weight_s1;
	assign wload = v_s1 && func_s1 == FUNC_LOAD_WEIGHT && letter_ok;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_bank
		prob_t wmem [MAX_ALPHABET];

		always_ff @(posedge clk) begin
			if (wload && 32'(pos_s1) == k) begin
				wmem[AW'(letter_s1)] <= wsat;
			end
			w_s3[k] <= wmem[code_s2];
		end
	end

	logic text_s3;
	logic found_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_s3 <= 1'b0;
		end else begin
			text_s3 <= text_s2;
		end
	end

	always_ff @(posedge clk) begin
		found_s3 <= found_s2;
	end

	// window cells
	prob_t            pp_q [MAX_PATTERN];
	prob_t            pp_nxt [MAX_PATTERN];
	logic [MW-1:0]    fill_q;
	logic [IDX_W-1:0] tpos_q;
	logic             text_s4;

	assign pp_nxt[0] = found_s3 ? w_s3[0] : '0;

	for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
		prob_t                wk;
		logic [2*Q_W-1:0]     prod;

		assign wk        = found_s3 ? w_s3[k] : '0;
		assign prod      = (2*Q_W)'(pp_q[k-1]) * (2*Q_W)'(wk);
		assign pp_nxt[k] = prod[Q_W+15:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				pp_q[k] <= '0;
			end
			fill_q  <= '0;
			tpos_q  <= '0;
			text_s4 <= 1'b0;
		end else begin
			text_s4 <= text_s3;
			if (text_s3) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					pp_q[k] <= pp_nxt[k];
				end
				if (fill_q < MW'(MAX_PATTERN)) begin
					fill_q <= fill_q + 1'b1;
				end
				tpos_q <= tpos_q + 1'b1;
			end
		end
	end

	// threshold compare
	logic [MW-1:0]    m_len;
	logic [MW-1:0]    m_last;
	logic             hit;
	logic [IDX_W-1:0] start_idx;

	always_comb begin
		if (pattern_length_q == '0) begin
			m_len = MW'(1);
		end else if (32'(pattern_length_q) > MAX_PATTERN) begin
			m_len = MW'(MAX_PATTERN);
		end else begin
			m_len = MW'(pattern_length_q);
		end
	end

	assign m_last    = m_len - 1'b1;
	assign hit       = fill_q >= m_len && pp_q[PW'(m_last)] >= min_probability_q;
	assign start_idx = tpos_q - IDX_W'(m_len);

	// result queue
	logic [IDX_W-1:0]  res_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              push;
	logic              pop;
	logic [CW-1:0]     pending;

	assign push      = text_s4 && hit;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign match_start = res_q[rd_ptr_q];

	assign pending  = cnt_q + CW'(v_s1) + CW'(text_s2) + CW'(text_s3) + CW'(text_s4);
	assign in_ready = pending < CW'(RES_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= start_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wpm_checker.sv]
// Port-level checks for the weighted pattern matcher, bound to the top level.
// Depends on wpm_pkg and weighted_pattern_matcher_defines.svh.
`default_nettype none

`include "weighted_pattern_matcher_defines.svh"

module wpm_port_checks (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic [wpm_pkg::FUNC_W-1:0]   func,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [wpm_pkg::IDX_W-1:0]    match_start
);
	import wpm_pkg::*;

	`WPM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(match_start))
	`WPM_ASSERT_IMP(a_full_has_result, !in_ready, out_valid)
	`WPM_ASSERT_IMP(a_result_from_text, $rose(out_valid), $past(in_valid && in_ready && func == FUNC_TEXT, 5))

endmodule

bind weighted_pattern_matcher wpm_port_checks u_wpm_port_checks (.*);

`default_nettype wire

[sim/wpm_checker.sv]
// Checker for the weighted pattern matcher: watches configuration writes and both beat channels,
// predicts each match_start from its own copy of the tables and window cells, and compares.
// Depends on wpm_pkg.
`default_nettype none

module wpm_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [wpm_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [wpm_pkg::Q_W-1:0]    cfg_wdata,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic [wpm_pkg::FUNC_W-1:0] func,
	input  wire logic [wpm_pkg::POS_W-1:0]  pattern_pos,
	input  wire logic [wpm_pkg::LET_W-1:0]  letter_index,
	input  wire logic [wpm_pkg::Q_W-1:0]    weight,
	input  wire logic [wpm_pkg::SYM_W-1:0]  symbol,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic [wpm_pkg::IDX_W-1:0]  match_start,
	output int unsigned                     fails,
	output int unsigned                     pending,
	output int unsigned                     results
);
	timeunit 1ns;
	timeprecision 1ps;
	import wpm_pkg::*;

	localparam int unsigned CELLS   = 64;
	localparam int unsigned LETTERS = 16;

	prob_t            weight_rows [CELLS][LETTERS];
	logic [SYM_W-1:0] letters [LETTERS];
	prob_t            window_prod [CELLS];
	logic [IDX_W-1:0] text_pos;
	int unsigned      filled;
	logic [PL_W-1:0]  len_reg;
	logic [AS_W-1:0]  asz_reg;
	prob_t            minp_reg;
	logic [IDX_W-1:0] starts_due [$];
	int unsigned      fail_cnt;
	int unsigned      match_cnt;

	task automatic extend_windows(input logic [SYM_W-1:0] sym, output bit hit,
			output logic [IDX_W-1:0] start);
		int unsigned m;
		int unsigned sig;
		int unsigned j;
		int unsigned k;
		bit found;
		logic [LET_W-1:0] code;
		prob_t w;
		logic [2*Q_W-1:0] prod;
		m = len_reg;
		if (m < 1) m = 1;
		if (m > CELLS) m = CELLS;
		sig = asz_reg;
		if (sig > LETTERS) sig = LETTERS;
		found = 1'b0;
		code = '0;
		for (j = 0; j < sig; j++) begin
			if (letters[j] == sym) begin
				found = 1'b1;
				code = LET_W'(j);
			end
		end
		for (k = CELLS - 1; k >= 1; k--) begin
			w = found ? weight_rows[k][code] : '0;
			prod = {{Q_W{1'b0}}, window_prod[k-1]} * {{Q_W{1'b0}}, w};
			window_prod[k] = prod[Q_W+15:16];
		end
		window_prod[0] = found ? weight_rows[0][code] : '0;
		if (filled < CELLS) filled++;
		start = text_pos - IDX_W'(m - 1);
		hit = (filled >= m) && (window_prod[m-1] >= minp_reg);
		text_pos = text_pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] due;
		bit hit;
		int i;
		int j;
		if (!arst_n) begin
			for (i = 0; i < CELLS; i++) begin
				window_prod[i] = '0;
				for (j = 0; j < LETTERS; j++) weight_rows[i][j] = '0;
			end
			for (j = 0; j < LETTERS; j++) letters[j] = '0;
			text_pos = '0;
			filled = 0;
			len_reg = PL_W'(1);
			asz_reg = AS_W'(4);
			minp_reg = ONE_Q16;
			starts_due.delete();
			fail_cnt = 0;
			match_cnt = 0;
			fails <= 0;
			pending <= 0;
			results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PATTERN_LENGTH:  len_reg = cfg_wdata[PL_W-1:0];
					CFG_ALPHABET_SIZE:   asz_reg = cfg_wdata[AS_W-1:0];
					CFG_MIN_PROBABILITY: minp_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (func)
					FUNC_LOAD_WEIGHT: begin
						weight_rows[pattern_pos][letter_index] =
							(weight > ONE_Q16) ? ONE_Q16 : weight;
					end
					FUNC_LOAD_LETTER: letters[letter_index] = symbol;
					FUNC_TEXT: begin
						extend_windows(symbol, hit, start);
						if (hit) starts_due.insert(starts_due.size(), start);
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				match_cnt++;
				if (starts_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: unexpected match_start %0d", match_start);
				end else begin
					due = starts_due.pop_front();
					if (match_start !== due) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch: match_start expected %0d actual %0d",
								due, match_start);
					end
				end
			end
			fails <= fail_cnt;
			pending <= starts_due.size();
			results <= match_cnt;
		end
	end

endmodule

`default_nettype wire

[sim/tb.sv]
// Top of the weighted pattern matcher testbench: clock, reset, configuration phases and beats.
// Drives the block with pattern-shaped text windows plus noise; wpm_checker gives the failures.
// Depends on wpm_pkg, weighted_pattern_matcher and wpm_checker.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpm_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;
	localparam logic [CFG_IW-1:0] CFG_SPARE  = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [Q_W-1:0]    cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  pattern_pos;
	logic [LET_W-1:0]  letter_index;
	logic [Q_W-1:0]    weight;
	logic [SYM_W-1:0]  symbol;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  match_start;

	int unsigned fails;
	int unsigned pending;
	int unsigned results;

	bit               steady;
	logic [SYM_W-1:0] alpha [16];
	logic [LET_W-1:0] fav [64];
	logic [PL_W-1:0]  cur_len;
	logic [AS_W-1:0]  cur_asz;
	int unsigned      items;

	logic [PL_W-1:0] dir_len [6] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd3, 7'd5};
	logic [AS_W-1:0] dir_asz [6] = '{5'd16, 5'd4, 5'd16, 5'd31, 5'd0, 5'd1};
	logic [Q_W-1:0]  dir_minp [6] = '{17'h10000, 17'd0, 17'd30000, 17'd20000, 17'd0, 17'h1FFFF};

	weighted_pattern_matcher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.pattern_pos  (pattern_pos),
		.letter_index (letter_index),
		.weight       (weight),
		.symbol       (symbol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_start  (match_start)
	);

	wpm_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.pattern_pos  (pattern_pos),
		.letter_index (letter_index),
		.weight       (weight),
		.symbol       (symbol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_start  (match_start),
		.fails        (fails),
		.pending      (pending),
		.results      (results)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	function automatic logic [Q_W-1:0] hi_weight();
		if ($urandom_range(0, 3) == 0) return {1'b1, 16'($urandom)};
		return ONE_Q16 - Q_W'($urandom_range(0, 300));
	endfunction

	function automatic int unsigned eff_len();
		if (cur_len == 0) return 1;
		if (cur_len > 64) return 64;
		return cur_len;
	endfunction

	function automatic int unsigned eff_sigma();
		if (cur_asz > 16) return 16;
		return cur_asz;
	endfunction

	// hold payload until accepted; next beat may follow at the same edge
	task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [LET_W-1:0] l, input logic [Q_W-1:0] w, input logic [SYM_W-1:0] s);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		pattern_pos  <= p;
		letter_index <= l;
		weight       <= w;
		symbol       <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f != FUNC_NOP) items++;
	endtask

	task automatic send_weight(input logic [POS_W-1:0] p, input logic [LET_W-1:0] l,
			input logic [Q_W-1:0] w);
		send_beat(FUNC_LOAD_WEIGHT, p, l, w, SYM_W'($urandom));
	endtask

	task automatic send_letter(input logic [LET_W-1:0] l, input logic [SYM_W-1:0] s);
		alpha[l] = s;
		send_beat(FUNC_LOAD_LETTER, POS_W'($urandom), l, Q_W'($urandom), s);
	endtask

	task automatic send_text(input logic [SYM_W-1:0] s);
		send_beat(FUNC_TEXT, POS_W'($urandom), LET_W'($urandom), Q_W'($urandom), s);
	endtask

	// drop valid, drain expected matches, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [Q_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [PL_W-1:0] len, input logic [AS_W-1:0] asz,
			input logic [Q_W-1:0] minp);
		cfg_write(CFG_PATTERN_LENGTH, Q_W'(len));
		cfg_write(CFG_ALPHABET_SIZE, Q_W'(asz));
		cfg_write(CFG_MIN_PROBABILITY, minp);
		cfg_we <= 1'b0;
		cur_len = len;
		cur_asz = asz;
	endtask

	task automatic repattern();
		int unsigned k;
		int unsigned sig;
		sig = eff_sigma();
		for (k = 0; k < eff_len(); k++) begin
			fav[k] = (sig == 0) ? LET_W'($urandom) : LET_W'($urandom_range(0, sig - 1));
			send_weight(POS_W'(k), fav[k], hi_weight());
		end
	endtask

	task automatic run_stream(input int unsigned n);
		int unsigned done;
		int unsigned r;
		int unsigned k;
		int unsigned len;
		int unsigned bad_k;
		logic [SYM_W-1:0] b;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			len = eff_len();
			if (r < 70) begin
				bad_k = ($urandom_range(0, 9) < 3) ? $urandom_range(0, len - 1) : len;
				for (k = 0; k < len; k++) begin
					b = (k == bad_k) ? SYM_W'($urandom) : alpha[fav[k]];
					send_text(b);
				end
				done += len;
			end else if (r < 80) begin
				b = $urandom_range(0, 1) ? alpha[$urandom_range(0, 15)] : SYM_W'($urandom);
				send_text(b);
				done++;
			end else if (r < 88) begin
				send_weight(POS_W'($urandom), LET_W'($urandom), Q_W'($urandom));
				done++;
			end else if (r < 92) begin
				send_letter(LET_W'($urandom), SYM_W'($urandom));
				done++;
			end else if (r < 95) begin
				send_beat(FUNC_NOP, POS_W'($urandom), LET_W'($urandom), Q_W'($urandom),
					SYM_W'($urandom));
			end else begin
				k = $urandom_range(0, len - 1);
				send_weight(POS_W'(k), fav[k], hi_weight());
				done++;
			end
		end
	endtask

	initial begin : ready_side
		int unsigned hold;
		bit nxt;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				hold--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				nxt = ($urandom_range(0, 2) != 0);
				out_ready <= nxt;
				hold = nxt ? $urandom_range(0, 20) : pick_gap();
			end
		end
	end

	initial begin : stimulus
		int unsigned j;
		int unsigned k;
		int unsigned ph;
		int unsigned r;
		logic [PL_W-1:0] l;
		logic [AS_W-1:0] a;
		logic [Q_W-1:0]  p;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		func         = FUNC_NOP;
		pattern_pos  = '0;
		letter_index = '0;
		weight       = '0;
		symbol       = '0;
		steady       = 1'b1;
		items        = 0;
		cur_len      = PL_W'(1);
		cur_asz      = AS_W'(4);
		for (k = 0; k < 64; k++) fav[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every table entry before any text beat reads one
		for (j = 0; j < 16; j++) send_letter(LET_W'(j), SYM_W'(8'h41 + j));
		for (k = 0; k < 64; k++)
			for (j = 0; j < 16; j++)
				send_weight(POS_W'(k), LET_W'(j), Q_W'($urandom_range(0, 65536)));
		items = 0;

		for (ph = 0; ph < 6 || items < 1300; ph++) begin
			if (ph < 6) begin
				l = dir_len[ph];
				a = dir_asz[ph];
				p = dir_minp[ph];
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) l = PL_W'($urandom_range(1, 8));
				else if (r < 85) l = PL_W'($urandom_range(9, 63));
				else if (r < 95) l = PL_W'(64);
				else l = $urandom_range(0, 1) ? PL_W'(0) : PL_W'($urandom_range(65, 127));
				r = $urandom_range(0, 99);
				if (r < 80) a = AS_W'($urandom_range(1, 16));
				else a = $urandom_range(0, 1) ? AS_W'(0) : AS_W'($urandom_range(17, 31));
				r = $urandom_range(0, 99);
				if (r < 10) p = '0;
				else if (r < 20) p = ONE_Q16;
				else if (r < 25) p = Q_W'($urandom_range(65537, 131071));
				else p = Q_W'($urandom_range(20000, 64000));
			end
			settle();
			if (ph == 0) cfg_write(CFG_SPARE, '1);
			set_config(l, a, p);
			steady <= (ph % 4 == 2);
			if (ph == 0) begin
				// duplicate letter: highest index wins; saturated weight; unknown byte
				send_letter(LET_W'(15), 8'hFF);
				send_letter(LET_W'(14), 8'hFF);
				send_weight(POS_W'(0), LET_W'(15), 17'h1FFFF);
				send_weight(POS_W'(0), LET_W'(14), 17'h00000);
				send_text(8'hFF);
				send_letter(LET_W'(0), 8'h00);
				send_weight(POS_W'(0), LET_W'(0), ONE_Q16);
				send_text(8'h00);
				send_text(8'h7E);
				send_beat(FUNC_NOP, '1, '1, '1, '1);
				send_weight(POS_W'(63), LET_W'(15), 17'h10001);
				send_weight(POS_W'(63), LET_W'(0), 17'h00000);
				send_text(8'h42);
				send_weight(POS_W'(0), LET_W'(1), 17'h0FFFF);
				send_text(8'h42);
				send_letter(LET_W'(1), 8'h42);
				send_text(8'hFF);
				send_text(8'h00);
			end
			repattern();
			run_stream(120);
		end
		settle();
		$display("covered %0d load and text beats over %0d configuration phases, %0d matches",
			items, ph, results);
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/wpm_pkg.sv
hw/rtl/weighted_pattern_matcher.sv
hw/rtl/wpm_checker.sv
sim/wpm_checker.sv
sim/tb.sv
